### hdl/fbpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbpb_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD      = 2'd1;
  localparam logic [1:0] ST_GEOMETRY = 2'd2;

  // FAT type codes.
  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;
  localparam logic [1:0] KIND_FAT32 = 2'd2;

  localparam logic [15:0] SIG_VALID        = 16'hAA55;
  localparam logic [15:0] MIN_SECTOR_BYTES = 16'd512;
  localparam int          DIR_ENTRY_SHIFT  = 5;      // 32 bytes per entry
  localparam logic [31:0] FAT12_LIMIT      = 32'd4085;
  localparam logic [31:0] FAT16_LIMIT      = 32'd65525;

  typedef struct packed {
    logic [15:0] signature_word;
    logic [15:0] sector_bytes;
    logic [7:0]  cluster_sectors;
    logic [15:0] reserved_count;
    logic [7:0]  fat_copies;
    logic [15:0] root_entries;
    logic [15:0] total_small;
    logic [31:0] total_wide;
    logic [15:0] fat_len_small;
    logic [31:0] fat_len_wide;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  fat_kind;
    logic [12:0] root_dir_count;
    logic [31:0] data_start;
    logic [31:0] cluster_total;
  } out_item_t;

  // Field check results handed from the decode logic to the first stage.
  typedef struct packed {
    logic        bad;
    logic [12:0] root;
    logic [2:0]  spc_log2;
  } chk_t;

  function automatic logic is_pow2_16(input logic [15:0] v);
    return (v != 16'd0) && ((v & (v - 16'd1)) == 16'd0);
  endfunction

  // Bit position of a one-hot word; OR of the indexes of the set bits.
  function automatic logic [3:0] onehot_log2_16(input logic [15:0] v);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        idx = idx | 4'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### hdl/fbpb_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fbpb_in_if;
  logic              valid;
  logic              ready;
  fbpb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fbpb_out_if;
  logic               valid;
  logic               ready;
  fbpb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/fbpb_field_check.sv
`timescale 1ns / 1ps
`default_nettype none

module fbpb_field_check (
  input  fbpb_pkg::in_item_t item,
  output fbpb_pkg::chk_t     chk
);

  logic       bps_ok;
  logic       spc_ok;
  logic [3:0] bps_log2;
  logic [3:0] spc_log2;
  logic [21:0] root_bytes;
  logic [21:0] root_shifted;

  assign bps_ok = (item.sector_bytes >= fbpb_pkg::MIN_SECTOR_BYTES)
                  && fbpb_pkg::is_pow2_16(item.sector_bytes);
  assign spc_ok = fbpb_pkg::is_pow2_16({8'd0, item.cluster_sectors});

  assign bps_log2 = fbpb_pkg::onehot_log2_16(item.sector_bytes);
  // Cluster sectors fit in eight bits, so the top bit of the position is always zero.
  assign spc_log2 = fbpb_pkg::onehot_log2_16({8'd0, item.cluster_sectors});

  // Root directory bytes rounded up to whole sectors.
  assign root_bytes = {1'b0, item.root_entries, 5'd0}
                      + {6'd0, item.sector_bytes - 16'd1};
  assign root_shifted = root_bytes >> bps_log2;

  always_comb begin
    chk.bad = (item.signature_word != fbpb_pkg::SIG_VALID) || !bps_ok || !spc_ok
              || (item.fat_copies == 8'd0) || (item.reserved_count == 16'd0);
    chk.root = root_shifted[12:0];
    chk.spc_log2 = spc_log2[2:0];
  end

endmodule

`default_nettype wire

### hdl/fat_bpb_check_and_type.sv
`timescale 1ns / 1ps
`default_nettype none

// FAT boot parameter block checker and type classifier. Each input word
// carries the end signature and the boot sector fields; each one yields
// exactly one result word, in order. The block is a five-stage pipeline
// (field check and size select, FAT area multiply, first data sector sum,
// cluster subtraction, cluster shift and classification into the output
// register), and a new word is taken every cycle unless the pipeline is full
// and the output is stalled. Each stage moves forward when the stage after it
// is empty or moving, so in_ch.ready falls only when every stage holds a
// word and the output is stalled. Status 1 flags a bad signature or field,
// status 2 a first data sector that does not fit in 32 bits or lies beyond
// the total sector count; any nonzero status zeroes the other fields.
module fat_bpb_check_and_type (
  input  wire           clk,
  input  wire           rst_n,
  fbpb_in_if.sink       in_ch,
  fbpb_out_if.source    out_ch
);

  fbpb_pkg::chk_t chk;

  fbpb_field_check u_check (
    .item (in_ch.data),
    .chk  (chk)
  );

  // Stage valid bits and advance enables.
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !out_valid_r || out_ch.ready;
  assign en4 = !s4_valid_r || en5;
  assign en3 = !s3_valid_r || en4;
  assign en2 = !s2_valid_r || en3;
  assign en1 = !s1_valid_r || en2;

  assign in_ch.ready = en1;
  assign out_ch.valid = out_valid_r;

  // Stage 1: checks, root directory size, total and FAT size selection.
  logic        s1_bad_r;
  logic [12:0] s1_root_r;
  logic [2:0]  s1_spc_log2_r;
  logic [15:0] s1_rsv_r;
  logic [7:0]  s1_nfat_r;
  logic [31:0] s1_total_r;
  logic [31:0] s1_fsz_r;

  // Stage 2: FAT area.
  logic        s2_bad_r;
  logic [12:0] s2_root_r;
  logic [2:0]  s2_spc_log2_r;
  logic [15:0] s2_rsv_r;
  logic [31:0] s2_total_r;
  logic [39:0] s2_fat_area_r;

  // Stage 3: first data sector and overflow check.
  logic [1:0]  s3_status_r;
  logic [12:0] s3_root_r;
  logic [2:0]  s3_spc_log2_r;
  logic [31:0] s3_total_r;
  logic [31:0] s3_start_r;

  // Stage 4: sectors left for data and underflow check.
  logic [1:0]  s4_status_r;
  logic [12:0] s4_root_r;
  logic [2:0]  s4_spc_log2_r;
  logic [31:0] s4_start_r;
  logic [31:0] s4_data_secs_r;

  fbpb_pkg::out_item_t out_data_r;

  logic [40:0] start_sum;
  logic [32:0] data_diff;
  logic [31:0] clusters;
  logic [1:0]  s3_status_nxt;
  logic [1:0]  s4_status_nxt;
  logic [1:0]  kind;

  assign start_sum = {25'd0, s2_rsv_r} + {1'b0, s2_fat_area_r} + {28'd0, s2_root_r};

  always_comb begin
    if (s2_bad_r) begin
      s3_status_nxt = fbpb_pkg::ST_BAD;
    end else if ((s2_fat_area_r[39:32] != 8'd0) || (start_sum[40:32] != 9'd0)) begin
      s3_status_nxt = fbpb_pkg::ST_GEOMETRY;
    end else begin
      s3_status_nxt = fbpb_pkg::ST_OK;
    end
  end

  assign data_diff = {1'b0, s3_total_r} - {1'b0, s3_start_r};

  always_comb begin
    if ((s3_status_r == fbpb_pkg::ST_OK) && data_diff[32]) begin
      s4_status_nxt = fbpb_pkg::ST_GEOMETRY;
    end else begin
      s4_status_nxt = s3_status_r;
    end
  end

  assign clusters = s4_data_secs_r >> s4_spc_log2_r;

  always_comb begin
    if (clusters < fbpb_pkg::FAT12_LIMIT) begin
      kind = fbpb_pkg::KIND_FAT12;
    end else if (clusters < fbpb_pkg::FAT16_LIMIT) begin
      kind = fbpb_pkg::KIND_FAT16;
    end else begin
      kind = fbpb_pkg::KIND_FAT32;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r  <= in_ch.valid;
      if (en2) s2_valid_r  <= s1_valid_r;
      if (en3) s3_valid_r  <= s2_valid_r;
      if (en4) s4_valid_r  <= s3_valid_r;
      if (en5) out_valid_r <= s4_valid_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_bad_r      <= chk.bad;
      s1_root_r     <= chk.root;
      s1_spc_log2_r <= chk.spc_log2;
      s1_rsv_r      <= in_ch.data.reserved_count;
      s1_nfat_r     <= in_ch.data.fat_copies;
      s1_total_r    <= (in_ch.data.total_small != 16'd0) ?
                       {16'd0, in_ch.data.total_small} : in_ch.data.total_wide;
      s1_fsz_r      <= (in_ch.data.fat_len_small != 16'd0) ?
                       {16'd0, in_ch.data.fat_len_small} : in_ch.data.fat_len_wide;
    end
    if (en2) begin
      s2_bad_r      <= s1_bad_r;
      s2_root_r     <= s1_root_r;
      s2_spc_log2_r <= s1_spc_log2_r;
      s2_rsv_r      <= s1_rsv_r;
      s2_total_r    <= s1_total_r;
      s2_fat_area_r <= {32'd0, s1_nfat_r} * {8'd0, s1_fsz_r};
    end
    if (en3) begin
      s3_status_r   <= s3_status_nxt;
      s3_root_r     <= s2_root_r;
      s3_spc_log2_r <= s2_spc_log2_r;
      s3_total_r    <= s2_total_r;
      s3_start_r    <= start_sum[31:0];
    end
    if (en4) begin
      s4_status_r    <= s4_status_nxt;
      s4_root_r      <= s3_root_r;
      s4_spc_log2_r  <= s3_spc_log2_r;
      s4_start_r     <= s3_start_r;
      s4_data_secs_r <= data_diff[31:0];
    end
    if (en5) begin
      out_data_r.status <= s4_status_r;
      if (s4_status_r == fbpb_pkg::ST_OK) begin
        out_data_r.fat_kind       <= kind;
        out_data_r.root_dir_count <= s4_root_r;
        out_data_r.data_start     <= s4_start_r;
        out_data_r.cluster_total  <= clusters;
      end else begin
        out_data_r.fat_kind       <= fbpb_pkg::KIND_FAT12;
        out_data_r.root_dir_count <= 13'd0;
        out_data_r.data_start     <= 32'd0;
        out_data_r.cluster_total  <= 32'd0;
      end
    end
  end

  assign out_ch.data = out_data_r;

  // A rejected word carries no geometry.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != fbpb_pkg::ST_OK)) |->
      (out_data_r.fat_kind == fbpb_pkg::KIND_FAT12) && (out_data_r.data_start == 32'd0)
      && (out_data_r.cluster_total == 32'd0) && (out_data_r.root_dir_count == 13'd0))
    else $error("rejected word has nonzero fields");

  // The type agrees with the cluster count.
  a_kind_fat12: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == fbpb_pkg::ST_OK)
     && (out_data_r.fat_kind == fbpb_pkg::KIND_FAT12)) |->
      (out_data_r.cluster_total < fbpb_pkg::FAT12_LIMIT))
    else $error("FAT12 with too many clusters");

  a_kind_fat32: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == fbpb_pkg::ST_OK)
     && (out_data_r.fat_kind == fbpb_pkg::KIND_FAT32)) |->
      (out_data_r.cluster_total >= fbpb_pkg::FAT16_LIMIT))
    else $error("FAT32 with too few clusters");

  // The root directory of an accepted volume never exceeds 4096 sectors.
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == fbpb_pkg::ST_OK)) |->
      (out_data_r.root_dir_count <= 13'd4096))
    else $error("root directory size out of range");

  // A stalled full pipeline refuses input.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_valid_r && s3_valid_r && s4_valid_r && out_valid_r
     && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while pipeline is full and stalled");

endmodule

`default_nettype wire

### tb/sv/fat_bpb_check_and_type_tb.sv
`timescale 1ns / 1ps

// Testbench for the FAT boot parameter block checker. Every input word is
// run through a local predictor when the block takes it, and the predicted
// result is queued. A checker process compares each result word that leaves
// the block, field by field, with the oldest queued prediction. The run is
// a short directed part followed by random volumes under several idling
// phases, plus one long output hold that fills the pipeline.
module fat_bpb_check_and_type_tb;

  // No handshake on either side for this many cycles means the block hung.
  localparam int STALL_LIMIT = 5000;
  // The pipeline is five stages deep.
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;

  fbpb_in_if  in_if ();
  fbpb_out_if out_if ();

  fat_bpb_check_and_type uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Traffic shaping, in percent per cycle: one rate for the sender, one for the receiver.
  int sender_idle_pct;
  int receiver_stall_pct;
  // A nonzero value asks the receiver to hold ready low for that many cycles.
  int hold_request;

  // Predicted results, oldest first.
  fbpb_pkg::out_item_t results_due[$];

  int error_count;
  int words_sent;
  int kind_count[3];
  int reject_count;
  int geometry_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Reports whether v has exactly one bit set and, if so, where it is. The
  // position is the shift that replaces a division by v.
  function automatic logic single_bit_at(input logic [15:0] v, output int pos);
    int ones;
    ones = 0;
    pos = 0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        ones++;
        pos = i;
      end
    end
    return ones == 1;
  endfunction

  // Works out the result word that one boot parameter block must give. All
  // sums are done at 64 bits so that anything beyond 32 bits can be caught.
  function automatic fbpb_pkg::out_item_t predict_volume(input fbpb_pkg::in_item_t bpb);
    fbpb_pkg::out_item_t r;
    logic [63:0] total, fat_len, root, fat_area, first_data, clusters;
    int          bps_shift, spc_shift;
    logic        bps_single, spc_single;
    r = '0;
    bps_single = single_bit_at(bpb.sector_bytes, bps_shift);
    spc_single = single_bit_at({8'd0, bpb.cluster_sectors}, spc_shift);
    // Any failed signature or field check gives status 1 and nothing else.
    if (bpb.signature_word != fbpb_pkg::SIG_VALID ||
        bpb.sector_bytes < fbpb_pkg::MIN_SECTOR_BYTES ||
        !bps_single || !spc_single || bpb.fat_copies == 8'd0 ||
        bpb.reserved_count == 16'd0) begin
      r.status = fbpb_pkg::ST_BAD;
      return r;
    end
    // A zero 16-bit field hands over to its 32-bit counterpart.
    total   = (bpb.total_small != 16'd0) ? {48'd0, bpb.total_small}
                                         : {32'd0, bpb.total_wide};
    fat_len = (bpb.fat_len_small != 16'd0) ? {48'd0, bpb.fat_len_small}
                                           : {32'd0, bpb.fat_len_wide};
    // Root directory sectors, rounded up to a whole sector.
    root = (({48'd0, bpb.root_entries} << fbpb_pkg::DIR_ENTRY_SHIFT) +
            {48'd0, bpb.sector_bytes} - 64'd1) >> bps_shift;
    fat_area   = {56'd0, bpb.fat_copies} * fat_len;
    first_data = {48'd0, bpb.reserved_count} + fat_area + root;
    // Overflow past 32 bits, or a data area that starts beyond the volume.
    if (fat_area > 64'hFFFF_FFFF || first_data > 64'hFFFF_FFFF || total < first_data) begin
      r.status = fbpb_pkg::ST_GEOMETRY;
      return r;
    end
    clusters = (total - first_data) >> spc_shift;
    r.status = fbpb_pkg::ST_OK;
    if (clusters < {32'd0, fbpb_pkg::FAT12_LIMIT}) begin
      r.fat_kind = fbpb_pkg::KIND_FAT12;
    end else if (clusters < {32'd0, fbpb_pkg::FAT16_LIMIT}) begin
      r.fat_kind = fbpb_pkg::KIND_FAT16;
    end else begin
      r.fat_kind = fbpb_pkg::KIND_FAT32;
    end
    r.root_dir_count = root[12:0];
    r.data_start     = first_data[31:0];
    r.cluster_total  = clusters[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender, receiver, checker and watchdog
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // Offers one word and returns at the edge where the block takes it. The
  // valid line is left high so that back-to-back words need no second
  // assignment in the same step; it is only lowered for an idle gap or at
  // the end of a phase.
  task automatic send_word(input fbpb_pkg::in_item_t bpb);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= bpb;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    results_due.push_back(predict_volume(bpb));
    words_sent++;
  endtask

  // Stops offering and waits until every predicted result has come back.
  // At least one edge always passes, so valid is never lowered and raised
  // again within one step.
  task automatic finish_phase();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  // The receiver drives ready at every edge, either from the stall rate or
  // low for the whole of a requested hold, which it counts down itself.
  initial begin : result_receiver
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Each result word taken from the block is checked against the oldest
  // prediction. All inputs change by nonblocking assignment, so the values
  // read here are those that the edge sampled.
  always @(posedge clk) begin : result_check
    fbpb_pkg::out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result word with no input word waiting for it");
      end else begin
        want = results_due.pop_front();
        if (out_if.data.status != want.status)
          report_mismatch($sformatf("status %0d, predicted %0d",
                                    out_if.data.status, want.status));
        if (out_if.data.fat_kind != want.fat_kind)
          report_mismatch($sformatf("fat_kind %0d, predicted %0d",
                                    out_if.data.fat_kind, want.fat_kind));
        if (out_if.data.root_dir_count != want.root_dir_count)
          report_mismatch($sformatf("root_dir_count %0d, predicted %0d",
                                    out_if.data.root_dir_count, want.root_dir_count));
        if (out_if.data.data_start != want.data_start)
          report_mismatch($sformatf("data_start %0d, predicted %0d",
                                    out_if.data.data_start, want.data_start));
        if (out_if.data.cluster_total != want.cluster_total)
          report_mismatch($sformatf("cluster_total %0d, predicted %0d",
                                    out_if.data.cluster_total, want.cluster_total));
        if (want.status == fbpb_pkg::ST_BAD) begin
          reject_count++;
        end else if (want.status == fbpb_pkg::ST_GEOMETRY) begin
          geometry_count++;
        end else begin
          kind_count[want.fat_kind]++;
        end
      end
    end
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin : hang_watch
    int quiet_cycles;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("No word moved for %0d cycles, %0d results still due.",
                 STALL_LIMIT, results_due.size());
        $display("FAIL fat_bpb_check_and_type");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // A well-formed small volume that the directed tests bend one field at a
  // time: 512-byte sectors, 8 per cluster, two FATs of 250 sectors and a
  // 32-sector root directory, so the data area starts at sector 564.
  function automatic fbpb_pkg::in_item_t good_volume();
    fbpb_pkg::in_item_t v;
    v.signature_word  = fbpb_pkg::SIG_VALID;
    v.sector_bytes    = 16'd512;
    v.cluster_sectors = 8'd8;
    v.reserved_count  = 16'd32;
    v.fat_copies      = 8'd2;
    v.root_entries    = 16'd512;
    v.total_small     = 16'd0;
    v.total_wide      = 32'd1_000_000;
    v.fat_len_small   = 16'd250;
    v.fat_len_wide    = 32'h0000_DEAD;
    return v;
  endfunction

  // Builds one random volume. Most are well formed, with the total chosen
  // so that the cluster count lands in a chosen band or on a type boundary;
  // some then get one field broken, and the rest are pure noise.
  function automatic fbpb_pkg::in_item_t random_volume();
    fbpb_pkg::in_item_t v;
    logic [63:0] first_data, span, total;
    logic [31:0] fat_len;
    int          bps_shift, spc_shift, shape;
    shape = $urandom_range(0, 99);
    if (shape < 15) begin
      v.signature_word  = 16'($urandom);
      v.sector_bytes    = 16'($urandom);
      v.cluster_sectors = 8'($urandom);
      v.reserved_count  = 16'($urandom);
      v.fat_copies      = 8'($urandom);
      v.root_entries    = 16'($urandom);
      v.total_small     = 16'($urandom);
      v.total_wide      = $urandom;
      v.fat_len_small   = 16'($urandom);
      v.fat_len_wide    = $urandom;
      if ($urandom_range(0, 1) == 1) v.signature_word = fbpb_pkg::SIG_VALID;
      return v;
    end
    bps_shift = $urandom_range(9, 15);
    spc_shift = $urandom_range(0, 7);
    v.signature_word  = fbpb_pkg::SIG_VALID;
    v.sector_bytes    = 16'd1 << bps_shift;
    v.cluster_sectors = 8'd1 << spc_shift;
    v.reserved_count  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                    : 16'($urandom_range(1, 64));
    v.fat_copies      = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                    : 8'($urandom_range(1, 2));
    v.root_entries    = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 1024));
    fat_len = ($urandom_range(0, 7) == 0) ? ($urandom >> $urandom_range(0, 31))
                                          : $urandom_range(1, 2048);
    if (fat_len != 32'd0 && fat_len < 32'd65536 && $urandom_range(0, 1) == 1) begin
      v.fat_len_small = fat_len[15:0];
      v.fat_len_wide  = $urandom;
    end else begin
      v.fat_len_small = 16'd0;
      v.fat_len_wide  = fat_len;
    end
    first_data = {48'd0, v.reserved_count} + {56'd0, v.fat_copies} * {32'd0, fat_len} +
                 ((({48'd0, v.root_entries} << fbpb_pkg::DIR_ENTRY_SHIFT) +
                   {48'd0, v.sector_bytes} - 64'd1) >> bps_shift);
    case ($urandom_range(0, 4))
      0: span = {32'd0, $urandom_range(0, 4084)};
      1: begin
        // Straddle one of the two type boundaries.
        span = {32'd0, $urandom_range(4083, 4086)};
        if ($urandom_range(0, 1) == 1) span = {32'd0, $urandom_range(65523, 65526)};
      end
      2: span = {32'd0, $urandom_range(4085, 65524)};
      default: span = {32'd0, $urandom_range(65525, 32'h0040_0000)};
    endcase
    total = first_data + (span << spc_shift) +
            {32'd0, $urandom_range(0, (1 << spc_shift) - 1)};
    // Now and then the volume ends just short of its data area.
    if ($urandom_range(0, 9) == 0) begin
      total = (first_data > 64'd16) ? first_data - {32'd0, $urandom_range(1, 16)} : 64'd0;
    end
    if (total != 64'd0 && total < 64'd65536 && $urandom_range(0, 1) == 1) begin
      v.total_small = total[15:0];
      v.total_wide  = $urandom;
    end else begin
      v.total_small = 16'd0;
      v.total_wide  = total[31:0];
    end
    if (shape < 30) begin
      case ($urandom_range(0, 5))
        0: v.signature_word = v.signature_word ^ (16'd1 << $urandom_range(0, 15));
        1: v.sector_bytes = 16'($urandom);
        2: v.cluster_sectors = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'($urandom);
        3: v.fat_copies = 8'd0;
        4: v.reserved_count = 16'd0;
        default: begin
          // Oversized FAT area.
          v.fat_copies    = 8'($urandom_range(2, 255));
          v.fat_len_small = 16'd0;
          v.fat_len_wide  = $urandom | 32'h8000_0000;
        end
      endcase
    end
    return v;
  endfunction

  // A wrong signature, and each basic field check that fails or just passes.
  task automatic test_signature_and_fields();
    fbpb_pkg::in_item_t v;
    sender_idle_pct = 30;
    receiver_stall_pct = 30;
    v = good_volume(); v.signature_word = 16'h0000;   send_word(v);
    v = good_volume(); v.signature_word = 16'hFFFF;   send_word(v);
    v = good_volume(); v.signature_word = 16'h55AA;   send_word(v);
    v = good_volume(); v.sector_bytes = 16'd0;        send_word(v);
    v = good_volume(); v.sector_bytes = 16'd256;      send_word(v);
    v = good_volume(); v.sector_bytes = 16'd768;      send_word(v);
    v = good_volume(); v.sector_bytes = 16'd32768;    send_word(v);
    v = good_volume(); v.cluster_sectors = 8'd0;      send_word(v);
    v = good_volume(); v.cluster_sectors = 8'd3;      send_word(v);
    v = good_volume(); v.cluster_sectors = 8'd255;    send_word(v);
    v = good_volume(); v.cluster_sectors = 8'd128;    send_word(v);
    v = good_volume(); v.fat_copies = 8'd0;           send_word(v);
    v = good_volume(); v.reserved_count = 16'd0;      send_word(v);
    finish_phase();
  endtask

  // FAT area past 32 bits, first data sector past 32 bits, a volume that
  // ends before its data area, and one that ends exactly where it begins.
  task automatic test_geometry_limits();
    fbpb_pkg::in_item_t v;
    v = good_volume();
    v.fat_copies = 8'd255; v.fat_len_small = 16'd0; v.fat_len_wide = 32'hFFFF_FFFF;
    send_word(v);
    v = good_volume();
    v.fat_copies = 8'd1; v.reserved_count = 16'h0020; v.root_entries = 16'd0;
    v.fat_len_small = 16'd0; v.fat_len_wide = 32'hFFFF_FFF0;
    send_word(v);
    v = good_volume(); v.total_small = 16'd100; send_word(v);
    v = good_volume(); v.total_small = 16'd564; send_word(v);
    finish_phase();
  endtask

  // Cluster counts on both sides of each type boundary, the largest wide
  // total, and the largest root directory.
  task automatic test_fat_kind_boundaries();
    fbpb_pkg::in_item_t v;
    // One reserved sector, one single-sector FAT and no root directory put
    // the data area at sector 2.
    v = good_volume();
    v.cluster_sectors = 8'd1; v.reserved_count = 16'd1; v.fat_copies = 8'd1;
    v.fat_len_small = 16'd1; v.root_entries = 16'd0;
    v.total_small = 16'd4086;  send_word(v);
    v.total_small = 16'd4087;  send_word(v);
    v.total_small = 16'd65526; send_word(v);
    v.total_small = 16'd65527; send_word(v);
    v = good_volume();
    v.cluster_sectors = 8'd128; v.fat_len_small = 16'd0; v.fat_len_wide = 32'h0001_0000;
    v.total_small = 16'd0; v.total_wide = 32'hFFFF_FFFF;
    send_word(v);
    v = good_volume(); v.root_entries = 16'hFFFF; send_word(v);
    finish_phase();
  endtask

  // The receiver holds off long enough for every stage to fill, while the
  // sender keeps offering words with no gaps, so the input must stall.
  task automatic test_output_hold();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request = 200;
    repeat (30) send_word(random_volume());
    finish_phase();
  endtask

  task automatic test_random_volumes(input int idle_pct, input int stall_pct, input int count);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_word(random_volume());
    finish_phase();
  endtask

  initial begin
    error_count = 0;
    words_sent = 0;
    reject_count = 0;
    geometry_count = 0;
    kind_count = '{0, 0, 0};
    hold_request = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_signature_and_fields();
    test_geometry_limits();
    test_fat_kind_boundaries();
    // Random volumes: no idling, a mostly idle sender, a mostly stalled
    // receiver, and light idling on both sides.
    test_random_volumes(0, 0, 175);
    test_random_volumes(78, 0, 175);
    test_random_volumes(0, 78, 175);
    test_random_volumes(9, 9, 175);
    test_output_hold();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", results_due.size()));
    $display("Checked %0d words: FAT12 %0d, FAT16 %0d, FAT32 %0d,",
             words_sent, kind_count[0], kind_count[1], kind_count[2]);
    $display("  %0d field rejects, %0d geometry errors.", reject_count, geometry_count);
    $display("Traffic ran without idling, with heavy and light idling on each side,");
    $display("  and one long output hold.");
    if (error_count == 0) begin
      $display("PASS fat_bpb_check_and_type");
    end else begin
      $display("FAIL fat_bpb_check_and_type");
    end
    $finish;
  end

endmodule

### fat_bpb_check_and_type.f
hdl/fbpb_pkg.sv
hdl/fbpb_if.sv
hdl/fbpb_field_check.sv
hdl/fat_bpb_check_and_type.sv
tb/sv/fat_bpb_check_and_type_tb.sv
